// ===== rtl/core/sil_pkg.sv =====
// Shared types and constants for the serial image loader.
// Holds the transfer payload structs, phase, status and register codes.
// No dependencies.
`default_nettype none

package sil_pkg;

    // Input transfer: a session start or one received serial byte.
    typedef struct packed {
        logic       action;
        logic [7:0] rx_byte;
    } in_t;

    // Output transfer: status plus an optional memory write.
    typedef struct packed {
        logic [2:0]  status;
        logic        mem_write;
        logic [31:0] mem_address;
        logic [7:0]  mem_data;
    } out_t;

    // Load session phases, one-hot.
    typedef enum logic [3:0] {
        PH_IDLE  = 4'b0001,
        PH_MAGIC = 4'b0010,
        PH_SIZE  = 4'b0100,
        PH_DATA  = 4'b1000
    } phase_t;

    localparam logic ACT_START = 1'b0;
    localparam logic ACT_BYTE  = 1'b1;

    localparam logic [2:0] ST_IGNORED     = 3'd0;
    localparam logic [2:0] ST_HEADER      = 3'd1;
    localparam logic [2:0] ST_BOOT_UNSAFE = 3'd2;
    localparam logic [2:0] ST_BAD_MAGIC   = 3'd3;
    localparam logic [2:0] ST_BAD_SIZE    = 3'd4;
    localparam logic [2:0] ST_BAD_TARGET  = 3'd5;
    localparam logic [2:0] ST_STORED      = 3'd6;
    localparam logic [2:0] ST_COMPLETE    = 3'd7;

    localparam logic [2:0] CFG_LOAD_BASE     = 3'd0;
    localparam logic [2:0] CFG_RELOC_START   = 3'd1;
    localparam logic [2:0] CFG_RELOC_END     = 3'd2;
    localparam logic [2:0] CFG_TREE_START    = 3'd3;
    localparam logic [2:0] CFG_TREE_END      = 3'd4;
    localparam logic [2:0] CFG_RAMDISK_START = 3'd5;
    localparam logic [2:0] CFG_RAMDISK_END   = 3'd6;
    localparam logic [2:0] CFG_GUARD_FLAGS   = 3'd7;

    // Bit positions within guard_flags.
    localparam int GUARD_BOOT_OK = 0;
    localparam int GUARD_TREE    = 1;
    localparam int GUARD_RAMDISK = 2;

    localparam logic [31:0] LOADER_MAGIC = 32'h544F_4F42;

    // Slot of the last byte of a little-endian header word.
    localparam logic [1:0] LAST_SLOT = 2'd3;

endpackage

`default_nettype wire

// ===== rtl/core/serial_image_loader_unit.sv =====
// Serial image loader: turns a received byte stream into boot image memory writes.
// Depends on sil_pkg for the payload structs, phase encoding and status codes.
//
//  Channel | Direction | Handshake               | Payload
//  --------+-----------+-------------------------+--------------------------------
//  in      | sink      | in_valid / in_stall     | sil_pkg::in_t  (action, rx_byte)
//  out     | source    | out_valid / out_stall   | sil_pkg::out_t (status, memory write)
//  cfg     | sink      | cfg_write (no wait)     | cfg_index, cfg_data
//
// Every input transfer yields exactly one output transfer, in the cycle after it is
// accepted. One item is accepted per cycle; the only limit is the single result
// register, so the input is stalled only while a held result is itself stalled.
// The deepest path is the header size check: one 33-bit add followed by parallel
// range compares, all into the result register.
// Reset (rst_n low, asynchronous) clears the configuration registers, the session
// state and the result valid flag.
`default_nettype none

module serial_image_loader_unit #(
    parameter int MAX_IMAGE_BYTES = 16777216
) (
    input  wire logic         clk,
    input  wire logic         rst_n,

    input  wire logic         in_valid,
    output logic              in_stall,
    input  wire sil_pkg::in_t in_data,

    output logic              out_valid,
    input  wire logic         out_stall,
    output sil_pkg::out_t     out_data,

    input  wire logic         cfg_write,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [31:0]  cfg_data
);

    // Width of the image length and byte counter: just enough to hold the maximum.
    localparam int LEN_W = $clog2(MAX_IMAGE_BYTES + 1);
    localparam logic [31:0] MAX_SIZE = 32'(MAX_IMAGE_BYTES);

    // Configuration registers.
    logic [31:0] load_base_reg;
    logic [31:0] reloc_start_reg;
    logic [31:0] reloc_end_reg;
    logic [31:0] tree_start_reg;
    logic [31:0] tree_end_reg;
    logic [31:0] ramdisk_start_reg;
    logic [31:0] ramdisk_end_reg;
    logic [2:0]  guard_flags_reg;

    // Session state. Header words are gathered in their low three bytes only:
    // the fourth byte arrives with the transfer that completes the word.
    sil_pkg::phase_t phase_reg, phase_next;
    logic [1:0]      slot_reg, slot_next;
    logic [23:0]     gather_reg, gather_next;
    logic [LEN_W-1:0] length_reg, length_next;
    logic [LEN_W-1:0] count_reg, count_next;

    // Result register.
    logic          out_valid_reg, out_valid_next;
    sil_pkg::out_t result_reg, result_next;

    logic        in_accept;
    logic [31:0] word_full;
    logic [32:0] window_end;
    logic [2:0]  size_status;
    logic [LEN_W-1:0] count_inc;

    // A blocked range is clear when the target window ends at or before its start,
    // or it ends at or before the window start. Empty or reversed ranges are taken as is.
    function automatic logic range_clear(
        input logic [32:0] win_end,
        input logic [31:0] win_start,
        input logic [31:0] blk_start,
        input logic [31:0] blk_end
    );
        return (win_end <= {1'b0, blk_start}) || (blk_end <= win_start);
    endfunction

    // A held result that is stalled blocks the next transfer; otherwise the result
    // register is free or empties in this same cycle.
    assign in_stall  = out_valid_reg & out_stall;
    assign in_accept = in_valid & ~in_stall;

    assign out_valid = out_valid_reg;
    assign out_data  = result_reg;

    // Header word as it stands once the current byte lands in the top slot.
    assign word_full  = {in_data.rx_byte, gather_reg};
    assign window_end = {1'b0, load_base_reg} + {1'b0, word_full};
    assign count_inc  = count_reg + LEN_W'(1);

    // Size and target window check, evaluated in parallel and prioritised here.
    always_comb
    begin
        priority if ((word_full == 32'd0) || (word_full > MAX_SIZE))
        begin
            size_status = sil_pkg::ST_BAD_SIZE;
        end
        else if (window_end[32])
        begin
            size_status = sil_pkg::ST_BAD_TARGET;
        end
        else if (!range_clear(window_end, load_base_reg, reloc_start_reg, reloc_end_reg))
        begin
            size_status = sil_pkg::ST_BAD_TARGET;
        end
        else if (guard_flags_reg[sil_pkg::GUARD_TREE] &&
                 !range_clear(window_end, load_base_reg, tree_start_reg, tree_end_reg))
        begin
            size_status = sil_pkg::ST_BAD_TARGET;
        end
        else if (guard_flags_reg[sil_pkg::GUARD_RAMDISK] &&
                 !range_clear(window_end, load_base_reg, ramdisk_start_reg, ramdisk_end_reg))
        begin
            size_status = sil_pkg::ST_BAD_TARGET;
        end
        else
        begin
            size_status = sil_pkg::ST_HEADER;
        end
    end

    // Next session state and result for the transfer being accepted.
    always_comb
    begin
        phase_next  = phase_reg;
        slot_next   = slot_reg;
        gather_next = gather_reg;
        length_next = length_reg;
        count_next  = count_reg;
        result_next = '0;

        if (in_accept)
        begin
            if (in_data.action == sil_pkg::ACT_START)
            begin
                // A start always drops any session in progress.
                slot_next   = '0;
                gather_next = '0;
                count_next  = '0;
                if (guard_flags_reg[sil_pkg::GUARD_BOOT_OK])
                begin
                    phase_next         = sil_pkg::PH_MAGIC;
                    result_next.status = sil_pkg::ST_HEADER;
                end
                else
                begin
                    phase_next         = sil_pkg::PH_IDLE;
                    result_next.status = sil_pkg::ST_BOOT_UNSAFE;
                end
            end
            else
            begin
                unique case (phase_reg)
                    sil_pkg::PH_IDLE:
                    begin
                        result_next.status = sil_pkg::ST_IGNORED;
                    end
                    sil_pkg::PH_MAGIC:
                    begin
                        result_next.status = sil_pkg::ST_HEADER;
                        slot_next          = slot_reg + 2'd1;
                        if (slot_reg == sil_pkg::LAST_SLOT)
                        begin
                            gather_next = '0;
                            if (word_full != sil_pkg::LOADER_MAGIC)
                            begin
                                result_next.status = sil_pkg::ST_BAD_MAGIC;
                                phase_next         = sil_pkg::PH_IDLE;
                            end
                            else
                            begin
                                phase_next = sil_pkg::PH_SIZE;
                            end
                        end
                        else
                        begin
                            gather_next = gather_reg |
                                          (24'(in_data.rx_byte) << {slot_reg, 3'b000});
                        end
                    end
                    sil_pkg::PH_SIZE:
                    begin
                        result_next.status = sil_pkg::ST_HEADER;
                        slot_next          = slot_reg + 2'd1;
                        if (slot_reg == sil_pkg::LAST_SLOT)
                        begin
                            gather_next        = '0;
                            result_next.status = size_status;
                            if (size_status == sil_pkg::ST_HEADER)
                            begin
                                length_next = word_full[LEN_W-1:0];
                                count_next  = '0;
                                phase_next  = sil_pkg::PH_DATA;
                            end
                            else
                            begin
                                phase_next = sil_pkg::PH_IDLE;
                            end
                        end
                        else
                        begin
                            gather_next = gather_reg |
                                          (24'(in_data.rx_byte) << {slot_reg, 3'b000});
                        end
                    end
                    sil_pkg::PH_DATA:
                    begin
                        // The address always follows the present load base.
                        result_next.mem_write   = 1'b1;
                        result_next.mem_address = load_base_reg +
                                                  {{(32 - LEN_W){1'b0}}, count_reg};
                        result_next.mem_data    = in_data.rx_byte;
                        count_next              = count_inc;
                        if (count_inc >= length_reg)
                        begin
                            result_next.status = sil_pkg::ST_COMPLETE;
                            phase_next         = sil_pkg::PH_IDLE;
                        end
                        else
                        begin
                            result_next.status = sil_pkg::ST_STORED;
                        end
                    end
                    default:
                    begin
                        result_next.status = sil_pkg::ST_IGNORED;
                        phase_next         = sil_pkg::PH_IDLE;
                    end
                endcase
            end
        end
    end

    // The result register fills on every accepted transfer and empties when taken.
    always_comb
    begin
        if (in_accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_stall)
        begin
            out_valid_next = out_valid_reg;
        end
        else
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= sil_pkg::PH_IDLE;
            slot_reg      <= '0;
            gather_reg    <= '0;
            length_reg    <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            slot_reg      <= slot_next;
            gather_reg    <= gather_next;
            length_reg    <= length_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload is only loaded on an accepted transfer.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            result_reg <= result_next;
        end
    end

    // Configuration writes take effect at once; the checks are not repeated.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_base_reg     <= '0;
            reloc_start_reg   <= '0;
            reloc_end_reg     <= '0;
            tree_start_reg    <= '0;
            tree_end_reg      <= '0;
            ramdisk_start_reg <= '0;
            ramdisk_end_reg   <= '0;
            guard_flags_reg   <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                sil_pkg::CFG_LOAD_BASE:     load_base_reg     <= cfg_data;
                sil_pkg::CFG_RELOC_START:   reloc_start_reg   <= cfg_data;
                sil_pkg::CFG_RELOC_END:     reloc_end_reg     <= cfg_data;
                sil_pkg::CFG_TREE_START:    tree_start_reg    <= cfg_data;
                sil_pkg::CFG_TREE_END:      tree_end_reg      <= cfg_data;
                sil_pkg::CFG_RAMDISK_START: ramdisk_start_reg <= cfg_data;
                sil_pkg::CFG_RAMDISK_END:   ramdisk_end_reg   <= cfg_data;
                sil_pkg::CFG_GUARD_FLAGS:   guard_flags_reg   <= cfg_data[2:0];
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== bench/tb_serial_image_loader_unit.sv =====
// Self-checking testbench for serial_image_loader_unit: it drives load sessions and noise,
// predicts every reply transfer and compares each one field by field.
// Depends on sil_pkg and on the loader RTL; it needs no other file.
`default_nettype none

module tb_serial_image_loader_unit;

    import sil_pkg::*;

    localparam int IMAGE_LIMIT = 16777216;
    localparam int REG_COUNT   = 8;
    localparam int ITEM_TARGET = 1500;
    localparam int QUIET_FROM  = 1250;
    localparam int CYCLE_LIMIT = 500000;

    // Predicts the reply to every accepted input transfer and keeps the replies
    // that are still due, oldest first.
    class image_load_tracker;
        bit [31:0] settings [REG_COUNT];
        phase_t    phase;
        bit [1:0]  slot;
        bit [31:0] gather;
        bit [24:0] length;
        bit [24:0] received;
        out_t      due_replies [$];
        int        failures;

        function new();
            foreach (settings[i]) settings[i] = '0;
            phase    = PH_IDLE;
            slot     = '0;
            gather   = '0;
            length   = '0;
            received = '0;
            failures = 0;
        endfunction

        function void set_register(logic [2:0] idx, logic [31:0] value);
            settings[idx] = (idx == CFG_GUARD_FLAGS) ? (value & 32'h7) : value;
        endfunction

        function bit loading();
            return phase == PH_DATA;
        endfunction

        function int unsigned bytes_left();
            return 32'(length - received);
        endfunction

        function int pending();
            return due_replies.size();
        endfunction

        // Places one header byte into the little-endian word; true once the word is whole.
        function bit take_byte(logic [7:0] b);
            gather = gather | (32'(b) << (8 * slot));
            slot   = slot + 2'd1;
            return slot == 2'd0;
        endfunction

        function bit clear_of(bit [32:0] lo, bit [32:0] hi, bit [31:0] b_lo, bit [31:0] b_hi);
            return (hi <= {1'b0, b_lo}) || ({1'b0, b_hi} <= lo);
        endfunction

        // Size and placement checks for a complete size word.
        function logic [2:0] judge_window(bit [31:0] size);
            bit [32:0] lo;
            bit [32:0] hi;
            lo = {1'b0, settings[CFG_LOAD_BASE]};
            hi = lo + 33'(size);
            if (size == 32'd0 || size > IMAGE_LIMIT)
                return ST_BAD_SIZE;
            if (hi > 33'h0_FFFF_FFFF)
                return ST_BAD_TARGET;
            if (!clear_of(lo, hi, settings[CFG_RELOC_START], settings[CFG_RELOC_END]))
                return ST_BAD_TARGET;
            if (settings[CFG_GUARD_FLAGS][GUARD_TREE]
                    && !clear_of(lo, hi, settings[CFG_TREE_START], settings[CFG_TREE_END]))
                return ST_BAD_TARGET;
            if (settings[CFG_GUARD_FLAGS][GUARD_RAMDISK]
                    && !clear_of(lo, hi, settings[CFG_RAMDISK_START], settings[CFG_RAMDISK_END]))
                return ST_BAD_TARGET;
            return ST_HEADER;
        endfunction

        function void note_transfer(in_t item);
            out_t res;
            res = '0;
            if (item.action == ACT_START) begin
                slot     = '0;
                gather   = '0;
                received = '0;
                if (settings[CFG_GUARD_FLAGS][GUARD_BOOT_OK]) begin
                    phase      = PH_MAGIC;
                    res.status = ST_HEADER;
                end
                else begin
                    phase      = PH_IDLE;
                    res.status = ST_BOOT_UNSAFE;
                end
            end
            else begin
                case (phase)
                    PH_MAGIC: begin
                        res.status = ST_HEADER;
                        if (take_byte(item.rx_byte)) begin
                            if (gather != LOADER_MAGIC) begin
                                res.status = ST_BAD_MAGIC;
                                phase      = PH_IDLE;
                            end
                            else begin
                                phase = PH_SIZE;
                            end
                            gather = '0;
                        end
                    end
                    PH_SIZE: begin
                        res.status = ST_HEADER;
                        if (take_byte(item.rx_byte)) begin
                            res.status = judge_window(gather);
                            if (res.status == ST_HEADER) begin
                                length   = gather[24:0];
                                received = '0;
                                phase    = PH_DATA;
                            end
                            else begin
                                phase = PH_IDLE;
                            end
                            gather = '0;
                        end
                    end
                    PH_DATA: begin
                        res.mem_write   = 1'b1;
                        res.mem_address = settings[CFG_LOAD_BASE] + 32'(received);
                        res.mem_data    = item.rx_byte;
                        received        = received + 25'd1;
                        if (received >= length) begin
                            res.status = ST_COMPLETE;
                            phase      = PH_IDLE;
                        end
                        else begin
                            res.status = ST_STORED;
                        end
                    end
                    default: res.status = ST_IGNORED;
                endcase
            end
            due_replies.push_back(res);
        endfunction

        function void check_transfer(out_t got);
            out_t want;
            if (due_replies.size() == 0) begin
                $error("unexpected reply transfer: status %0d, address %h",
                       got.status, got.mem_address);
                failures++;
                return;
            end
            want = due_replies.pop_front();
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                failures++;
            end
            if (got.mem_write !== want.mem_write) begin
                $error("mem_write: expected %0d, got %0d", want.mem_write, got.mem_write);
                failures++;
            end
            if (got.mem_address !== want.mem_address) begin
                $error("mem_address: expected %h, got %h", want.mem_address, got.mem_address);
                failures++;
            end
            if (got.mem_data !== want.mem_data) begin
                $error("mem_data: expected %h, got %h", want.mem_data, got.mem_data);
                failures++;
            end
        endfunction
    endclass

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    in_t         in_data   = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    out_t        out_data;
    logic        cfg_write = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data  = '0;

    image_load_tracker tracker = new();

    // Register values last chosen for the loader; the stimulus aims its sizes
    // and blocked ranges at the present load base.
    logic [31:0] plan [REG_COUNT];

    // Idle-burst odds, one in gap_odds per input item or reply cycle; zero means none.
    int gap_odds  = 5;
    int stall_run = 0;
    int sent      = 0;
    int elapsed   = 0;

    serial_image_loader_unit #(.MAX_IMAGE_BYTES(IMAGE_LIMIT)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        elapsed++;
        if (elapsed > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Reply side: check each accepted transfer, then decide the stall for the next cycle.
    always @(posedge clk)
    begin
        if (out_valid && !out_stall)
            tracker.check_transfer(out_data);
        if (stall_run != 0) begin
            stall_run--;
            out_stall <= 1'b1;
        end
        else if (gap_odds != 0 && $urandom_range(0, gap_odds - 1) == 0) begin
            stall_run = $urandom_range(0, 16);
            out_stall <= 1'b1;
        end
        else begin
            out_stall <= 1'b0;
        end
    end

    // Offers one input transfer and returns at the edge where it is accepted, with
    // valid still high so that a following transfer can go out back to back.
    task automatic send_item(input logic act, input logic [7:0] value);
        in_t item;
        item.action  = act;
        item.rx_byte = value;
        if (gap_odds != 0 && $urandom_range(0, gap_odds - 1) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        tracker.note_transfer(item);
        sent++;
    endtask

    task automatic send_word(input logic [31:0] w);
        for (int k = 0; k < 4; k++)
            send_item(ACT_BYTE, w[8 * k +: 8]);
    endtask

    // Stops offering input and waits until every reply has come back.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (tracker.pending() != 0) @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    // Writes the planned value of every register whose bit is set in mask.
    task automatic write_plan(input logic [REG_COUNT-1:0] mask);
        for (int i = 0; i < REG_COUNT; i++) begin
            if (mask[i]) begin
                cfg_write <= 1'b1;
                cfg_index <= 3'(i);
                cfg_data  <= plan[i];
                @(posedge clk);
                tracker.set_register(3'(i), plan[i]);
            end
        end
        cfg_write <= 1'b0;
    endtask

    // A blocked range: empty, all-covering, reversed, close around the load base
    // so that short images straddle its edges, or somewhere at random.
    task automatic place_range(input logic [2:0] idx_lo, input logic [2:0] idx_hi);
        logic [31:0] anchor;
        anchor = plan[CFG_LOAD_BASE] + $urandom_range(0, 100) - 50;
        case ($urandom_range(0, 9))
            0: begin
                plan[idx_lo] = '0;
                plan[idx_hi] = '0;
            end
            1: begin
                plan[idx_lo] = '0;
                plan[idx_hi] = 32'hFFFF_FFFF;
            end
            2: begin
                plan[idx_lo] = anchor + $urandom_range(1, 40);
                plan[idx_hi] = anchor;
            end
            3, 4: begin
                plan[idx_lo] = anchor;
                plan[idx_hi] = anchor + $urandom_range(0, 40);
            end
            default: begin
                plan[idx_lo] = $urandom;
                plan[idx_hi] = plan[idx_lo] + $urandom_range(1, 1 << 20);
            end
        endcase
    endtask

    task automatic pick_settings();
        logic [31:0] g;
        case ($urandom_range(0, 5))
            0: plan[CFG_LOAD_BASE] = '0;
            1: plan[CFG_LOAD_BASE] = 32'hFFFF_FFFF;
            2: plan[CFG_LOAD_BASE] = 32'hFFFF_FFFF - $urandom_range(0, 60);
            default: plan[CFG_LOAD_BASE] = $urandom;
        endcase
        place_range(CFG_RELOC_START, CFG_RELOC_END);
        place_range(CFG_TREE_START, CFG_TREE_END);
        place_range(CFG_RAMDISK_START, CFG_RAMDISK_END);
        // The upper bits are junk that the loader must drop.
        g = $urandom;
        g[GUARD_BOOT_OK] = ($urandom_range(0, 7) != 0);
        plan[CFG_GUARD_FLAGS] = g;
        write_plan('1);
    endtask

    // One session: mostly a sound header with random content, sometimes a cut-off
    // header or a damaged magic word. Long images are abandoned part-way, so the
    // next start transfer drops them.
    task automatic run_session();
        logic [31:0] size;
        int unsigned pick;
        int unsigned cut;
        int unsigned idx;
        send_item(ACT_START, 8'($urandom));
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
            repeat ($urandom_range(0, 6)) send_item(ACT_BYTE, 8'($urandom));
            return;
        end
        if (pick == 1)
            send_word(LOADER_MAGIC ^ (32'h1 << $urandom_range(0, 31)));
        else
            send_word(LOADER_MAGIC);
        case ($urandom_range(0, 15))
            0: size = '0;
            1: size = IMAGE_LIMIT;
            2: size = IMAGE_LIMIT + 1;
            3: size = $urandom;
            4: size = 32'hFFFF_FFFF;
            5: size = 32'd0 - plan[CFG_LOAD_BASE];
            6: size = 32'hFFFF_FFFF - plan[CFG_LOAD_BASE];
            7: size = $urandom_range(49, 100000);
            default: size = $urandom_range(1, 40);
        endcase
        send_word(size);
        cut = $urandom_range(4, 30);
        while (tracker.loading()) begin
            if (tracker.bytes_left() > 48 && cut == 0)
                return;
            if (cut != 0)
                cut--;
            // Now and then a register changes mid-payload; the loader must use the
            // new load base at once without repeating its checks.
            if ($urandom_range(0, 59) == 0) begin
                idx = $urandom_range(0, REG_COUNT - 1);
                plan[idx] = $urandom;
                settle();
                write_plan(REG_COUNT'(1) << idx);
            end
            send_item(ACT_BYTE, 8'($urandom));
        end
    endtask

    initial
    begin
        int sessions_left;
        sessions_left = 0;
        foreach (plan[i]) plan[i] = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. The boot check is still clear, so a start is refused and
        // a byte with no session open is ignored.
        plan[CFG_LOAD_BASE]     = 32'h0000_1000;
        plan[CFG_RELOC_START]   = 32'h0000_0000;
        plan[CFG_RELOC_END]     = 32'h0000_0100;
        plan[CFG_TREE_START]    = 32'h0000_2000;
        plan[CFG_TREE_END]      = 32'h0000_3000;
        plan[CFG_RAMDISK_START] = 32'hFFFF_0000;
        plan[CFG_RAMDISK_END]   = 32'hFFFF_FFFF;
        plan[CFG_GUARD_FLAGS]   = '0;
        write_plan('1);
        send_item(ACT_START, 8'h00);
        send_item(ACT_BYTE, 8'hFF);
        settle();

        // All guard bits set, written through a full word of ones.
        plan[CFG_GUARD_FLAGS] = 32'hFFFF_FFFF;
        write_plan(REG_COUNT'(1) << CFG_GUARD_FLAGS);

        // A one-byte image: its only byte is stored and completes the load.
        send_item(ACT_START, 8'hFF);
        send_word(LOADER_MAGIC);
        send_word(32'd1);
        send_item(ACT_BYTE, 8'hFF);

        // A wrong final magic byte.
        send_item(ACT_START, 8'h00);
        send_word(32'h554F_4F42);

        // A start in the middle of a header restarts the session; then an image one
        // byte over the limit is refused.
        send_item(ACT_START, 8'h00);
        send_item(ACT_BYTE, 8'h42);
        send_item(ACT_START, 8'h00);
        send_word(LOADER_MAGIC);
        send_word(IMAGE_LIMIT + 1);
        settle();

        // Random part: phases of a few sessions, each phase with fresh settings and
        // its own idling pressure, some phases with no idling at all.
        while (sent < ITEM_TARGET) begin
            if (sessions_left == 0) begin
                settle();
                pick_settings();
                sessions_left = $urandom_range(2, 6);
                case ($urandom_range(0, 3))
                    0: gap_odds = 0;
                    1: gap_odds = 2;
                    2: gap_odds = 5;
                    default: gap_odds = 10;
                endcase
            end
            if (sent > QUIET_FROM)
                gap_odds = 0;
            if ($urandom_range(0, 4) == 0)
                repeat ($urandom_range(1, 3)) send_item(1'($urandom_range(0, 1)), 8'($urandom));
            run_session();
            sessions_left--;
        end

        settle();
        if (tracker.failures == 0 && tracker.pending() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire
